FILE: hw/rtl/fpa_pkg.sv
// Package: operation codes, channel payload types and the pipeline item type.
package fpa_pkg;

    // Operation codes
    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_LT       = 4'd5,
        OP_GE       = 4'd6,
        OP_LE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_FROM_INT = 4'd14,
        OP_TO_INT   = 4'd15
    } fpa_op_t;

    typedef struct packed {
        logic [3:0]         operation;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } fpa_in_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               compare_true;
        logic               divide_by_zero;
    } fpa_out_t;

    // Item travelling down the divider chain
    typedef struct packed {
        fpa_op_t     op;
        logic [31:0] fast;   // result of every non-divide, non-compare operation
        logic        cmp;
        logic        dz;
        logic        neg;    // quotient sign
        logic [31:0] rem;    // partial remainder
        logic [31:0] dvd;    // dividend magnitude, consumed MSB first
        logic [31:0] dsr;    // divisor magnitude
        logic [31:0] quo;    // low 32 quotient bits
    } fpa_item_t;

endpackage

FILE: hw/rtl/fpa_entry.sv
// Entry stage: decodes the operation, computes all non-divide results, sets up divide.
module fpa_entry
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic      req_valid,
    input  fpa_in_t   req,
    output logic      vld,
    output fpa_item_t item
);

    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [63:0] prod;
    logic               vld_reg;
    fpa_item_t          item_reg;
    fpa_item_t          item_next;

    assign a    = req.operand_a;
    assign b    = req.operand_b;
    assign prod = a * b;

    // Operation decode
    always_comb
    begin
        item_next      = '0;
        item_next.op   = fpa_op_t'(req.operation);
        item_next.neg  = a[31] ^ b[31];
        item_next.dvd  = a[31] ? 32'(-a) : 32'(a);
        item_next.dsr  = b[31] ? 32'(-b) : 32'(b);
        item_next.dz   = (fpa_op_t'(req.operation) == OP_DIV) && (b == 32'sd0);
        unique case (fpa_op_t'(req.operation))
            OP_ADD:      item_next.fast = 32'(a + b);
            OP_SUB:      item_next.fast = 32'(a - b);
            OP_MUL:      item_next.fast = prod[FRAC_BITS+31:FRAC_BITS];
            OP_DIV:      item_next.fast = '0;
            OP_GT:       item_next.cmp  = (a > b);
            OP_LT:       item_next.cmp  = (a < b);
            OP_GE:       item_next.cmp  = (a >= b);
            OP_LE:       item_next.cmp  = (a <= b);
            OP_EQ:       item_next.cmp  = (a == b);
            OP_NE:       item_next.cmp  = (a != b);
            OP_MIN:      item_next.fast = (a < b) ? a : b;
            OP_MAX:      item_next.fast = (a > b) ? a : b;
            OP_INC:      item_next.fast = 32'(a + 32'sd1);
            OP_DEC:      item_next.fast = 32'(a - 32'sd1);
            OP_FROM_INT: item_next.fast = a <<< FRAC_BITS;
            OP_TO_INT:   item_next.fast = a >>> FRAC_BITS;
            default:     item_next.fast = '0;
        endcase
    end

    // Stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= item_next;
        end
    end

    assign vld  = vld_reg;
    assign item = item_reg;

endmodule

FILE: hw/rtl/fpa_div_cell.sv
// Divider cell: one restoring quotient bit per cell, registered toward its neighbor.
module fpa_div_cell
    import fpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic      vld_in,
    input  fpa_item_t item_in,
    output logic      vld_out,
    output fpa_item_t item_out
);

    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;
    logic        vld_reg;
    fpa_item_t   item_reg;
    fpa_item_t   item_next;

    // Shift in next dividend bit, trial subtract
    assign trial = {item_in.rem, item_in.dvd[31]};
    assign diff  = trial - {1'b0, item_in.dsr};
    assign ge    = (trial >= {1'b0, item_in.dsr});

    always_comb
    begin
        item_next     = item_in;
        item_next.rem = ge ? diff[31:0] : trial[31:0];
        item_next.quo = {item_in.quo[30:0], ge};
        item_next.dvd = {item_in.dvd[30:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= item_next;
        end
    end

    assign vld_out  = vld_reg;
    assign item_out = item_reg;

endmodule

FILE: hw/rtl/fixed_point_alu.sv
// Top level: signed 32-bit fixed-point ALU built as an entry stage and a chain of divider cells.
// Accepts one operation per clock while the output is not stalled, and returns one result per operation, in order.
// Every operation travels the same pipeline of 34 + FRAC_BITS register stages
// (entry stage, 32 + FRAC_BITS divider cells, output register); the chain of
// one-bit divider cells accounts for most of that depth.
// The whole pipeline stalls only while the output register holds an untaken result.
module fixed_point_alu
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  fpa_in_t  req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output fpa_out_t rsp
);

    localparam int NCELL = 32 + FRAC_BITS;

    logic        adv;
    logic        vld   [0:NCELL];
    fpa_item_t   chain [0:NCELL];
    logic        rsp_valid_reg;
    fpa_out_t    rsp_reg;
    fpa_out_t    rsp_next;
    logic [31:0] quo_signed;

    // Global advance: move when output is free or being taken
    assign adv       = !rsp_valid_reg || rsp_ready;
    assign req_ready = adv;

    fpa_entry #(
        .FRAC_BITS (FRAC_BITS)
    ) u_entry (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .req_valid (req_valid),
        .req       (req),
        .vld       (vld[0]),
        .item      (chain[0])
    );

    // Divider chain
    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++)
        begin : g_cell
            fpa_div_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .adv      (adv),
                .vld_in   (vld[gi]),
                .item_in  (chain[gi]),
                .vld_out  (vld[gi+1]),
                .item_out (chain[gi+1])
            );
        end
    endgenerate

    // Result select
    assign quo_signed = chain[NCELL].neg ? 32'(-chain[NCELL].quo) : chain[NCELL].quo;

    always_comb
    begin
        rsp_next                = '0;
        rsp_next.compare_true   = chain[NCELL].cmp;
        rsp_next.divide_by_zero = chain[NCELL].dz;
        if (chain[NCELL].op == OP_DIV)
        begin
            rsp_next.result_value = chain[NCELL].dz ? 32'sd0 : $signed(quo_signed);
        end
        else
        begin
            rsp_next.result_value = $signed(chain[NCELL].fast);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            rsp_valid_reg <= vld[NCELL];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.divide_by_zero |-> rsp.result_value == 32'sd0)
        else $error("divide by zero with nonzero result");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.compare_true && rsp.divide_by_zero))
        else $error("compare and divide flags both set");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("output changed while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready == (!rsp_valid || rsp_ready))
        else $error("input ready mismatch with output stall");

endmodule
